FILE: rtl/mrh_pkg.sv
// ----------------------------------------------------------------------------
// mrh_pkg
// Shared types, constants and helpers for the residue-class histogram: the
// command codes, register indexes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mrh_pkg;

   // Default sizes handed to the top level.
   localparam int MAX_BINS_DEF    = 256;
   localparam int VALUE_WIDTH_DEF = 16;

   // Fixed field widths.
   localparam int CMD_W       = 2;
   localparam int OPERAND_W   = 16;
   localparam int COUNT_W     = 16;
   localparam int MODULUS_W   = 8;
   localparam int LIMIT_W     = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 40;

   // Register reset values and the count ceiling.
   localparam logic [MODULUS_W-1:0] MODULUS_RESET = 8'd1;
   localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 16'd3000;
   localparam logic [COUNT_W-1:0]   COUNT_MAX     = 16'hFFFF;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT   = 1'b1;

   // Request command codes.
   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } mrh_cmd_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_DECODE,
      ST_DIV1,
      ST_RANGE,
      ST_DIV2,
      ST_READ,
      ST_APPLY,
      ST_RESULT
   } mrh_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;      // take the request into the working registers
      logic decode;       // prime the result fields
      logic clear_total;  // zero the accepted total and restart the sweep
      logic div_load;     // load the divider
      logic div_phase2;   // with div_load: reduce the residue by the bin count
      logic div_step;     // one restoring division step
      logic mem_read;     // read the addressed bin
      logic apply;        // write back the bin and total, or latch the read
      logic sweep_step;   // zero one bin of the store
      logic result_load;  // move the result into the output register
   } mrh_ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      mrh_cmd_type cmd;          // command of the current request
      logic        in_limit;     // sample is not above the limit
      logic        rd_in_range;  // read index addresses a stored bin
      logic        div_last;     // the current division step is the final one
      logic        res_ge_bins;  // residue lies beyond the store
      logic        sweep_last;   // the sweep is on its final bin
      logic        rsp_free;     // the output register can take a result
   } mrh_status_type;

   // Saturating increment of a count.
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      logic [COUNT_W-1:0] r;
      r = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
      return r;
   endfunction

endpackage

FILE: rtl/modulo_residue_histogram.sv
// ----------------------------------------------------------------------------
// modulo_residue_histogram
// Histogram of sample values by residue modulo a configured modulus, with a
// value limit, clear, add and read requests and saturating counts.
//
//   Channel   Direction  Contents
//   req_      in         command and operand of one request
//   rsp_      out        bin count, accepted total, accepted flag
//   csr_      in         write of modulus (index 0) or value limit (index 1)
//
// An add runs the bit-serial divider over SAMPLE_W bits, SAMPLE_W being
// the sample width (16 by default); a residue at or above MAX_BINS takes
// a second division pass by MAX_BINS. A read, a rejected sample, an unused
// command or a read beyond the store does not use the divider.
// A clear sweeps the store, one bin zeroed per cycle.
// After reset a sweep of all MAX_BINS bins clears the store; no request is
// taken until it ends. A stalled response holds the next result back.
// ----------------------------------------------------------------------------
module modulo_residue_histogram
   import mrh_pkg::*;
#(
   parameter int MAX_BINS    = MAX_BINS_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // command[1:0], operand[17:2]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // bin_count[15:0], total_counted[31:16],
                                               // accepted[32]
   input  logic                   csr_wen,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   mrh_ctrl_type   ctrl;
   mrh_status_type status;

   // Sequencer.
   mrh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .ctrl       (ctrl)
   );

   // Divider, store and output register.
   mrh_datapath #(
      .MAX_BINS    (MAX_BINS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .status      (status),
      .req_command (req_tdata[CMD_W-1:0]),
      .req_operand (req_tdata[CMD_W +: OPERAND_W]),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

FILE: rtl/mrh_ctrl.sv
// ----------------------------------------------------------------------------
// mrh_ctrl
// Sequencer of the histogram: clearing sweep, request decode, the two
// division passes, the read-modify-write of a bin and the result hand-off.
// ----------------------------------------------------------------------------
module mrh_ctrl
   import mrh_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  mrh_status_type status,
   output mrh_ctrl_type   ctrl
);

   mrh_state_type state_ff, state_in;
   logic          reply_ff, reply_in;

   // State register; reset starts with a sweep of the whole store.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         reply_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         reply_ff <= reply_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      reply_in   = reply_ff;
      req_tready = 1'b0;
      ctrl       = '0;
      unique case (state_ff)
         ST_SWEEP: begin
            ctrl.sweep_step = 1'b1;
            if (status.sweep_last) begin
               state_in = reply_ff ? ST_RESULT : ST_IDLE;
               reply_in = 1'b0;
            end
         end
         ST_IDLE: begin
            req_tready   = 1'b1;
            ctrl.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            ctrl.decode = 1'b1;
            unique case (status.cmd)
               CMD_CLEAR: begin
                  ctrl.clear_total = 1'b1;
                  reply_in         = 1'b1;
                  state_in         = ST_SWEEP;
               end
               CMD_ADD: begin
                  if (status.in_limit) begin
                     ctrl.div_load = 1'b1;
                     state_in      = ST_DIV1;
                  end else begin
                     state_in = ST_RESULT;
                  end
               end
               CMD_READ: begin
                  state_in = status.rd_in_range ? ST_READ : ST_RESULT;
               end
               CMD_NONE: begin
                  state_in = ST_RESULT;
               end
               default: begin
                  state_in = ST_RESULT;
               end
            endcase
         end
         ST_DIV1: begin
            ctrl.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_RANGE;
            end
         end
         ST_RANGE: begin
            if (status.res_ge_bins) begin
               ctrl.div_load   = 1'b1;
               ctrl.div_phase2 = 1'b1;
               state_in        = ST_DIV2;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_DIV2: begin
            ctrl.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            ctrl.mem_read = 1'b1;
            state_in      = ST_APPLY;
         end
         ST_APPLY: begin
            ctrl.apply = 1'b1;
            state_in   = ST_RESULT;
         end
         ST_RESULT: begin
            if (status.rsp_free) begin
               ctrl.result_load = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/mrh_datapath.sv
// ----------------------------------------------------------------------------
// mrh_datapath
// Working registers, configuration registers, bit-serial restoring divider,
// the bin store with its registered read, the accepted total and the
// output register.
// ----------------------------------------------------------------------------
module mrh_datapath
   import mrh_pkg::*;
#(
   parameter int MAX_BINS    = MAX_BINS_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mrh_ctrl_type           ctrl,
   output mrh_status_type         status,
   input  logic [CMD_W-1:0]       req_command,
   input  logic [OPERAND_W-1:0]   req_operand,
   input  logic                   csr_wen,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int SAMPLE_W = (VALUE_WIDTH < OPERAND_W) ? VALUE_WIDTH : OPERAND_W;
   localparam int DIV_MAX  = (MAX_BINS > 255) ? MAX_BINS : 255;
   localparam int DIV_W    = $clog2(DIV_MAX + 1);
   localparam int IDX_W    = $clog2(MAX_BINS);
   localparam int STEP_W   = $clog2(SAMPLE_W);
   localparam int PAD_W    = RSP_TDATA_W - 2 * COUNT_W - 1;

   // Configuration registers.
   logic [MODULUS_W-1:0] modulus_ff;
   logic [LIMIT_W-1:0]   limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET;
         limit_ff   <= LIMIT_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_MODULUS: modulus_ff <= csr_wdata[MODULUS_W-1:0];
            CSR_LIMIT:   limit_ff   <= csr_wdata[LIMIT_W-1:0];
            default:     ;
         endcase
      end
   end

   // Request registers; the limit check is made as the request comes in.
   mrh_cmd_type          cmd_ff;
   logic [OPERAND_W-1:0] operand_ff;
   logic                 in_limit_ff;

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff      <= mrh_cmd_type'(req_command);
         operand_ff  <= req_operand;
         in_limit_ff <= (OPERAND_W'(req_operand[SAMPLE_W-1:0]) <= limit_ff);
      end
   end

   // Restoring divider, one dividend bit per cycle.
   logic [DIV_W-1:0]    rem_ff;
   logic [DIV_W-1:0]    divisor_ff;
   logic [SAMPLE_W-1:0] dvd_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [DIV_W:0]      trial;
   logic                trial_ge;

   assign trial    = {rem_ff, dvd_ff[SAMPLE_W-1]};
   assign trial_ge = (trial >= {1'b0, divisor_ff});

   always_ff @(posedge clock) begin
      if (ctrl.div_load) begin
         rem_ff  <= '0;
         step_ff <= '0;
         if (ctrl.div_phase2) begin
            divisor_ff <= DIV_W'(MAX_BINS);
            dvd_ff     <= SAMPLE_W'(rem_ff);
         end else begin
            divisor_ff <= (modulus_ff == '0) ? DIV_W'(1) : DIV_W'(modulus_ff);
            dvd_ff     <= operand_ff[SAMPLE_W-1:0];
         end
      end else if (ctrl.div_step) begin
         rem_ff  <= trial_ge ? DIV_W'(trial - {1'b0, divisor_ff}) : trial[DIV_W-1:0];
         dvd_ff  <= {dvd_ff[SAMPLE_W-2:0], 1'b0};
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   // Clearing sweep counter; reset starts a sweep from the first bin.
   logic [IDX_W-1:0] sweep_ff;
   logic             sweep_last;

   assign sweep_last = (sweep_ff == IDX_W'(MAX_BINS - 1));

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear_total) begin
         sweep_ff <= '0;
      end else if (ctrl.sweep_step) begin
         sweep_ff <= sweep_last ? '0 : sweep_ff + IDX_W'(1);
      end
   end

   // Bin store: one write port, one registered read port.
   logic [COUNT_W-1:0] bin_mem [MAX_BINS];
   logic [COUNT_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]   bin_idx;
   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   wr_addr;
   logic [COUNT_W-1:0] wr_data;
   logic               wr_en;
   logic               apply_add;

   assign bin_idx   = rem_ff[IDX_W-1:0];
   assign rd_addr   = (cmd_ff == CMD_ADD) ? bin_idx : operand_ff[IDX_W-1:0];
   assign apply_add = ctrl.apply && (cmd_ff == CMD_ADD);
   assign wr_en     = ctrl.sweep_step || apply_add;
   assign wr_addr   = ctrl.sweep_step ? sweep_ff : bin_idx;
   assign wr_data   = ctrl.sweep_step ? '0 : sat_inc(rd_data_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bin_mem[wr_addr] <= wr_data;
      end
      if (ctrl.mem_read) begin
         rd_data_ff <= bin_mem[rd_addr];
      end
   end

   // Accepted total.
   logic [COUNT_W-1:0] total_ff;

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear_total) begin
         total_ff <= '0;
      end else if (apply_add) begin
         total_ff <= sat_inc(total_ff);
      end
   end

   // Result fields of the current request.
   logic [COUNT_W-1:0] bin_count_ff;
   logic               acc_ff;

   always_ff @(posedge clock) begin
      if (ctrl.decode) begin
         bin_count_ff <= '0;
         acc_ff       <= (cmd_ff == CMD_ADD) && in_limit_ff;
      end else if (ctrl.apply && (cmd_ff == CMD_READ)) begin
         bin_count_ff <= rd_data_ff;
      end
   end

   // Output register.
   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.result_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.result_load) begin
         rsp_data_ff <= {{PAD_W{1'b0}}, acc_ff, total_ff, bin_count_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Status to the controller.
   assign status.cmd         = cmd_ff;
   assign status.in_limit    = in_limit_ff;
   assign status.rd_in_range = (operand_ff < OPERAND_W'(MAX_BINS));
   assign status.div_last    = (step_ff == STEP_W'(SAMPLE_W - 1));
   assign status.res_ge_bins = (rem_ff >= DIV_W'(MAX_BINS));
   assign status.sweep_last  = sweep_last;
   assign status.rsp_free    = !rsp_valid_ff || rsp_tready;

`ifndef SYNTHESIS
   // After a division step the partial remainder is below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.div_step |=> (rem_ff < divisor_ff))
      else $error("divider remainder not below divisor");

   // A bin update always addresses a bin inside the store.
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.mem_read && (cmd_ff == CMD_ADD)) |-> (rem_ff < DIV_W'(MAX_BINS)))
      else $error("bin index beyond the store");

   // A counted sample leaves a non-zero total behind.
   assert property (@(posedge clock) disable iff (reset)
      apply_add |=> (total_ff != '0))
      else $error("total not advanced by a counted sample");

   // A result is loaded only into a free output register.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.result_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwrote a pending response");
`endif

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stand-alone testbench for the residue-class histogram. A driver offers
// queued requests in random bursts, a receiver accepts responses on its own
// stall pattern, and a monitor predicts every response from a model of the
// bin store kept here. It compares each response with the oldest prediction.
// The run covers directed corner requests and randomised phases under
// several register settings.
// ----------------------------------------------------------------------------
module tb;
   import mrh_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HIST_BINS = MAX_BINS_DEF;

   typedef struct packed {
      mrh_cmd_type          cmd;
      logic [OPERAND_W-1:0] operand;
   } hist_request_type;

   typedef struct packed {
      logic [COUNT_W-1:0] bin_count;
      logic [COUNT_W-1:0] total;
      logic               accepted;
   } hist_result_type;

   // Block ports.
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wen    = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // Request and prediction queues.
   hist_request_type queued_requests[$];
   hist_result_type  predicted_results[$];

   // Model state of the histogram.
   logic [COUNT_W-1:0]   bin_store [HIST_BINS];
   logic [COUNT_W-1:0]   sample_total = '0;
   logic [MODULUS_W-1:0] cfg_modulus  = MODULUS_RESET;
   logic [LIMIT_W-1:0]   cfg_limit    = LIMIT_RESET;

   // Driver and receiver control.
   logic        req_taken   = 1'b0;
   logic        hold_armed  = 1'b0;
   logic        hold_used   = 1'b0;
   int unsigned hold_left   = 0;
   int unsigned burst_left  = 0;
   int unsigned gap_left    = 0;
   int unsigned stall_mode  = 0;
   int unsigned stall_left  = 0;
   int unsigned mismatch_count = 0;
   int unsigned result_index   = 0;

   modulo_residue_histogram dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Clock generation.
   initial begin
      forever #5 clock = ~clock;
   end

   // Predicts one response and updates the model store for one request.
   function automatic hist_result_type histogram_step(input hist_request_type rq);
      hist_result_type      r;
      logic [OPERAND_W-1:0] sample;
      int unsigned          divisor;
      int unsigned          slot;
      r = '0;
      case (rq.cmd)
         CMD_CLEAR: begin
            foreach (bin_store[i]) bin_store[i] = '0;
            sample_total = '0;
         end
         CMD_ADD: begin
            sample = rq.operand[VALUE_WIDTH_DEF-1:0];
            if (sample <= cfg_limit) begin
               // A zero modulus behaves as a modulus of one.
               divisor = (cfg_modulus == 0) ? 1 : cfg_modulus;
               slot    = (sample % divisor) % HIST_BINS;
               if (bin_store[slot] != COUNT_MAX)
                  bin_store[slot] = bin_store[slot] + 1'b1;
               if (sample_total != COUNT_MAX) sample_total = sample_total + 1'b1;
               r.accepted = 1'b1;
            end
         end
         CMD_READ: begin
            // Indexes beyond the store read as zero.
            if (rq.operand < HIST_BINS) r.bin_count = bin_store[rq.operand];
         end
         default: begin
         end
      endcase
      r.total = sample_total;
      return r;
   endfunction

   // Monitor: tracks register writes, predicts on each accepted request and
   // checks each accepted response against the oldest prediction.
   always @(posedge clock) begin : monitor_proc
      hist_request_type rq;
      hist_result_type  seen;
      hist_result_type  want;
      req_taken <= req_tvalid && req_tready;
      if (reset) begin
         foreach (bin_store[i]) bin_store[i] = '0;
         sample_total = '0;
         cfg_modulus  = MODULUS_RESET;
         cfg_limit    = LIMIT_RESET;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_MODULUS: cfg_modulus = csr_wdata[MODULUS_W-1:0];
               CSR_LIMIT:   cfg_limit   = csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            rq.cmd     = mrh_cmd_type'(req_tdata[CMD_W-1:0]);
            rq.operand = req_tdata[CMD_W +: OPERAND_W];
            predicted_results.push_back(histogram_step(rq));
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.bin_count = rsp_tdata[15:0];
            seen.total     = rsp_tdata[31:16];
            seen.accepted  = rsp_tdata[32];
            if (predicted_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response %0d with no request outstanding: %s %0d %0d %0b",
                           result_index, "bin/total/acc", seen.bin_count, seen.total,
                           seen.accepted);
            end else begin
               want = predicted_results.pop_front();
               if (seen.bin_count !== want.bin_count || seen.total !== want.total ||
                   seen.accepted !== want.accepted) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"response %0d: expected bin %0d total %0d acc %0b, ",
                               "got bin %0d total %0d acc %0b"},
                              result_index, want.bin_count, want.total, want.accepted,
                              seen.bin_count, seen.total, seen.accepted);
               end
            end
            result_index++;
         end
      end
   end

   // Driver: presents queued requests in bursts separated by random gaps.
   always @(negedge clock) begin : driver_proc
      hist_request_type next_req;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (queued_requests.size() != 0) begin
            next_req = queued_requests.pop_front();
            req_tdata  <= {{(REQ_TDATA_W - CMD_W - OPERAND_W){1'b0}},
                           next_req.operand, next_req.cmd};
            req_tvalid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(0, 12);
               gap_left   = $urandom_range(1, 10);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: stalls on its own changing pattern, with one long hold-off.
   always @(negedge clock) begin : receiver_proc
      if (hold_armed && !hold_used) begin
         hold_left = 400;
         hold_used = 1'b1;
      end
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(16, 128);
      end else begin
         stall_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (reset) begin
         rsp_tready <= 1'b1;
      end else begin
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   task automatic offer(input mrh_cmd_type c, input logic [OPERAND_W-1:0] op);
      queued_requests.push_back('{cmd: c, operand: op});
   endtask

   // Register write, only issued while the block is idle.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wen   <= 1'b0;
   endtask

   // Waits until every queued request has been taken and answered.
   task automatic wait_drained();
      while (queued_requests.size() != 0 || req_tvalid || predicted_results.size() != 0)
         @(posedge clock);
   endtask

   // Stimulus sequence.
   initial begin
      int unsigned          mod_val;
      int unsigned          lim_val;
      int unsigned          pick;
      int unsigned          top;
      logic [OPERAND_W-1:0] op;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: limit edges, rejected samples and out-of-range reads.
      offer(CMD_READ, 16'd0);
      offer(CMD_ADD, 16'd0);
      offer(CMD_ADD, 16'd3000);
      offer(CMD_ADD, 16'd3001);
      offer(CMD_ADD, 16'hFFFF);
      offer(CMD_READ, 16'd0);
      offer(CMD_READ, 16'd256);
      offer(CMD_READ, 16'hFFFF);
      offer(CMD_NONE, 16'hFFFF);
      wait_drained();

      // A zero modulus sends every sample to bin zero.
      write_register(CSR_MODULUS, 16'd0);
      write_register(CSR_LIMIT, 16'hFFFF);
      offer(CMD_ADD, 16'hFFFF);
      offer(CMD_ADD, 16'hAAAA);
      offer(CMD_READ, 16'd0);
      wait_drained();

      // Largest modulus with the smallest limit.
      write_register(CSR_MODULUS, 16'd255);
      write_register(CSR_LIMIT, 16'd0);
      offer(CMD_ADD, 16'd0);
      offer(CMD_ADD, 16'd1);
      wait_drained();

      write_register(CSR_LIMIT, 16'hFFFF);
      offer(CMD_ADD, 16'd254);
      offer(CMD_ADD, 16'd509);
      offer(CMD_ADD, 16'h5555);
      offer(CMD_READ, 16'd254);
      offer(CMD_READ, 16'd255);
      wait_drained();

      // A smaller modulus leaves the upper bins stale until a clear.
      write_register(CSR_MODULUS, 16'd7);
      offer(CMD_ADD, 16'd20);
      offer(CMD_READ, 16'd254);
      offer(CMD_READ, 16'd6);
      offer(CMD_CLEAR, 16'd0);
      offer(CMD_READ, 16'd254);
      offer(CMD_NONE, 16'd0);
      wait_drained();

      // Random phases, each under its own register settings.
      for (int setting = 0; setting < 5; setting++) begin
         case (setting)
            0: begin
               mod_val = $urandom_range(2, 16);
               lim_val = $urandom_range(200, 3000);
            end
            1: begin
               mod_val = 255;
               lim_val = 16'hFFFF;
            end
            2: begin
               mod_val = 0;
               lim_val = $urandom_range(0, 65535);
            end
            3: begin
               mod_val = $urandom_range(1, 255);
               lim_val = $urandom_range(0, 65535);
            end
            default: begin
               mod_val = $urandom_range(100, 255);
               lim_val = $urandom_range(0, 200);
            end
         endcase
         write_register(CSR_MODULUS, 16'(mod_val));
         write_register(CSR_LIMIT, 16'(lim_val));
         repeat (85) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               offer(CMD_CLEAR, 16'($urandom));
            end else if (pick < 63) begin
               // Most samples fall near or under the limit.
               top = (lim_val > 65515) ? 65535 : lim_val + 20;
               op  = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, top)) : 16'($urandom);
               offer(CMD_ADD, op);
            end else if (pick < 95) begin
               pick = $urandom_range(0, 9);
               if (pick < 7)
                  op = 16'($urandom_range(0, HIST_BINS - 1));
               else if (pick < 9)
                  op = 16'($urandom_range(0, (mod_val > 1) ? mod_val - 1 : 0));
               else
                  op = 16'($urandom);
               offer(CMD_READ, op);
            end else begin
               offer(CMD_NONE, 16'($urandom));
            end
         end
         // Stall the receiver for a long stretch while requests keep coming.
         if (setting == 1) hold_armed = 1'b1;
         wait_drained();
      end

      // Let any stray response show up before the verdict.
      repeat (64) @(posedge clock);
      if (mismatch_count == 0 && predicted_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(100ms);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
